>>> rtl/core/ccq_pkg.sv
`timescale 1ns / 1ps

package ccq_pkg;

   // Queue geometry and card field widths
   localparam int QUEUE_DEPTH  = 4;
   localparam int TYPE_BITS    = 4;
   localparam int PAYLOAD_BITS = 32;
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [TYPE_BITS-1:0]    card_kind_type;
   typedef logic [PAYLOAD_BITS-1:0] card_data_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   // Request codes
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_START  = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // One request word
   typedef struct packed {
      op_type        req_type;
      card_kind_type in_type;
      card_data_type in_payload;
   } req_word_type;

   // One result word
   typedef struct packed {
      logic          started;
      card_kind_type card_type;
      card_data_type card_payload;
      logic          merged;
      logic          dropped;
      count_type     queue_depth;
      logic          running;
      card_kind_type head_type;
      card_data_type head_payload;
   } rsp_word_type;

endpackage

>>> rtl/core/ccq_queue.sv
`timescale 1ns / 1ps

module ccq_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  ccq_pkg::req_word_type step_word,
   input  ccq_pkg::card_kind_type urgent_type,
   output ccq_pkg::rsp_word_type  step_result
);
   import ccq_pkg::*;

   card_kind_type slot_type_ff    [QUEUE_DEPTH];
   card_data_type slot_payload_ff [QUEUE_DEPTH];
   card_kind_type slot_type_in    [QUEUE_DEPTH];
   card_data_type slot_payload_in [QUEUE_DEPTH];
   count_type     count_ff, count_in;
   logic          busy_ff, busy_in;

   // after optional drop of the oldest card
   card_kind_type base_type    [QUEUE_DEPTH];
   card_data_type base_payload [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] hit;
   logic          found, full, grant;
   count_type     count_drop;

   // parallel type compare against the waiting cards
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit[i] = (count_type'(i) < count_ff) && (slot_type_ff[i] == step_word.in_type);
      end
   end

   assign found      = |hit;
   assign full       = (count_ff == count_type'(QUEUE_DEPTH));
   assign grant      = !busy_ff && (count_ff != '0);
   assign count_drop = full ? count_ff - count_type'(1) : count_ff;

   // slots after dropping the head of a full queue
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (full && i < QUEUE_DEPTH - 1) begin
            base_type[i]    = slot_type_ff[i+1];
            base_payload[i] = slot_payload_ff[i+1];
         end else begin
            base_type[i]    = slot_type_ff[i];
            base_payload[i] = slot_payload_ff[i];
         end
      end
   end

   // next state of the store
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_type_in[i]    = slot_type_ff[i];
         slot_payload_in[i] = slot_payload_ff[i];
      end
      count_in = count_ff;
      busy_in  = busy_ff;
      unique case (step_word.req_type)
         OP_PUSH: begin
            if (found) begin
               // types are unique in the queue, so at most one hit
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (hit[i]) begin
                     slot_payload_in[i] = step_word.in_payload;
                  end
               end
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (step_word.in_type == urgent_type) begin
                     if (i == 0) begin
                        slot_type_in[i]    = step_word.in_type;
                        slot_payload_in[i] = step_word.in_payload;
                     end else begin
                        slot_type_in[i]    = base_type[i-1];
                        slot_payload_in[i] = base_payload[i-1];
                     end
                  end else if (count_type'(i) == count_drop) begin
                     slot_type_in[i]    = step_word.in_type;
                     slot_payload_in[i] = step_word.in_payload;
                  end else begin
                     slot_type_in[i]    = base_type[i];
                     slot_payload_in[i] = base_payload[i];
                  end
               end
               count_in = count_drop + count_type'(1);
            end
         end
         OP_START: begin
            if (grant) begin
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  slot_type_in[i]    = slot_type_ff[i+1];
                  slot_payload_in[i] = slot_payload_ff[i+1];
               end
               count_in = count_ff - count_type'(1);
               busy_in  = 1'b1;
            end
         end
         OP_FINISH: begin
            busy_in = 1'b0;
         end
         OP_CLEAR: begin
            count_in = '0;
            busy_in  = 1'b0;
         end
         default: begin
            busy_in = busy_ff;
         end
      endcase
   end

   // result word for this step
   always_comb begin
      step_result              = '0;
      step_result.started      = (step_word.req_type == OP_START) && grant;
      step_result.merged       = (step_word.req_type == OP_PUSH) && found;
      step_result.dropped      = (step_word.req_type == OP_PUSH) && !found && full;
      step_result.queue_depth  = count_in;
      step_result.running      = busy_in;
      if (step_result.started) begin
         step_result.card_type    = slot_type_ff[0];
         step_result.card_payload = slot_payload_ff[0];
      end
      if (count_in != '0) begin
         step_result.head_type    = slot_type_in[0];
         step_result.head_payload = slot_payload_in[0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else if (step_valid) begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   // card slots, no reset
   always_ff @(posedge clock) begin
      if (step_valid) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_type_ff[i]    <= slot_type_in[i];
            slot_payload_ff[i] <= slot_payload_in[i];
         end
      end
   end

endmodule

>>> rtl/core/coalescing_card_queue.sv
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Handshake
// request   start, busy, req_data          in         start & !busy
// result    rsp_strobe, rsp_data           out        strobe, one cycle
// config    csr_we, csr_data               in         csr_we
//
// A word is taken into the input register, processed in the following cycle
// and its result is registered and appears on rsp_data in the cycle after
// that; one word per cycle sustained, set by the single register stage
// around the queue store. busy stays low. Synchronous reset empties the
// queue, clears the running flag and sets urgent_type to zero. The receiver
// cannot stall, so nothing holds the pipeline.

module coalescing_card_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ccq_pkg::req_word_type req_data,
   output logic                  rsp_strobe,
   output ccq_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  ccq_pkg::card_kind_type csr_data
);
   import ccq_pkg::*;

   req_word_type  req_ff;
   logic          req_valid_ff;
   card_kind_type urgent_ff;
   rsp_word_type  step_result;
   rsp_word_type  rsp_ff;
   logic          rsp_strobe_ff;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= req_data;
      end
   end

   // urgent type register
   always_ff @(posedge clock) begin
      if (reset) begin
         urgent_ff <= '0;
      end else if (csr_we) begin
         urgent_ff <= csr_data;
      end
   end

   ccq_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (req_valid_ff),
      .step_word   (req_ff),
      .urgent_type (urgent_ff),
      .step_result (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
